/* hdl/sfr_pkg.sv */
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

  localparam int unsigned MAX_LEN   = 8;
  localparam int unsigned LEN_CAP   = 8;
  localparam int unsigned WIN_DEPTH = (MAX_LEN < LEN_CAP) ? MAX_LEN : LEN_CAP;
  localparam int unsigned OUT_DEPTH = LEN_CAP;
  localparam int unsigned CNT_W     = $clog2(OUT_DEPTH + 1);
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned CFG_W     = 64;

  typedef enum logic [1:0] {
    CFG_PAT_LEN   = 2'd0,
    CFG_PAT_BYTES = 2'd1,
    CFG_REP_LEN   = 2'd2,
    CFG_REP_BYTES = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
    logic       doc_end;
  } out_req_t;

  // Window cell control: capture on a request, shift toward the oldest slot.
  typedef struct packed {
    logic en;
    logic shift;
  } win_ctrl_t;

  // Output cell control: load a fresh burst or advance toward the head.
  typedef struct packed {
    logic load;
    logic pop;
  } out_ctrl_t;

endpackage

/* hdl/sfr_win_cell.sv */
// One byte slot of the search window, with its pattern compare.
module sfr_win_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfr_pkg::win_ctrl_t ctrl_i,
  input  logic              sel_i,
  input  logic [7:0]        char_i,
  input  logic [7:0]        nb_ins_i,
  input  logic [7:0]        pat_i,
  output logic [7:0]        ins_o,
  output logic              match_o
);
  import sfr_pkg::*;

  logic [7:0] byte_q, byte_d;

  // The incoming byte lands in the slot that the fill count points at.
  assign ins_o   = sel_i ? char_i : byte_q;
  assign match_o = (ins_o == pat_i);
  assign byte_d  = ctrl_i.shift ? nb_ins_i : ins_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (ctrl_i.en) begin
      byte_q <= byte_d;
    end
  end

endmodule

/* hdl/sfr_out_cell.sv */
// One byte slot of the output burst chain.
module sfr_out_cell (
  input  logic              clk_i,
  input  sfr_pkg::out_ctrl_t ctrl_i,
  input  logic [7:0]        load_i,
  input  logic [7:0]        nb_i,
  output logic [7:0]        byte_o
);
  import sfr_pkg::*;

  logic [7:0] byte_q, byte_d;

  assign byte_d = ctrl_i.load ? load_i : nb_i;
  assign byte_o = byte_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load || ctrl_i.pop) begin
      byte_q <= byte_d;
    end
  end

endmodule

/* hdl/stream_find_replace.sv */
// Streaming find-and-replace: window cell row plus output burst chain.
//
//   channel  | direction | handshake               | payload
//   in       | input     | in_valid_i / in_stall_o  | in_req_i  (in_char, in_last)
//   out      | output    | out_valid_o / out_stall_i| out_req_o (out_char, run_end, doc_end)
//   cfg      | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// A request is taken when the output chain is empty or its last byte leaves that cycle,
// so an item with one result sustains one item per cycle while the output does not stall;
// an item with n results (at most 8) leaves the chain one byte a cycle from its head,
// unless stalled. Window compare and burst build sit in the request cycle; the first result
// shows in the cycle after the request. Reset clears the window, fill count, chain count and
// cfg registers. Output stall holds the head byte and stalls the input once a burst waits.
module stream_find_replace (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  sfr_pkg::cfg_idx_e          cfg_idx_i,
  input  logic [sfr_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  sfr_pkg::in_req_t           in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output sfr_pkg::out_req_t          out_req_o
);
  import sfr_pkg::*;

  logic [LEN_W-1:0] pat_len_q, rep_len_q;
  logic [63:0]      pat_bytes_q, rep_bytes_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             doc_q, doc_d;

  logic [CNT_W-1:0] plen, rlen, fill1, burst_cnt;
  logic             accept, pop, plen_zero, full, match_all, step;
  logic [WIN_DEPTH-1:0] cell_match, len_mask;
  logic [7:0]       win_ins [WIN_DEPTH];
  logic [7:0]       burst   [OUT_DEPTH];
  logic [7:0]       out_byte[OUT_DEPTH];
  win_ctrl_t        win_ctrl;
  out_ctrl_t        out_ctrl;

  // Effective lengths saturate at the window and replacement capacity.
  assign plen = (pat_len_q > LEN_W'(WIN_DEPTH)) ? CNT_W'(WIN_DEPTH) : CNT_W'(pat_len_q);
  assign rlen = (rep_len_q > LEN_W'(LEN_CAP)) ? CNT_W'(LEN_CAP) : CNT_W'(rep_len_q);
  assign plen_zero = (plen == '0);

  assign pop        = out_valid_o && !out_stall_i;
  assign in_stall_o = !((cnt_q == '0) || ((cnt_q == CNT_W'(1)) && pop));
  assign accept     = in_valid_i && !in_stall_o;
  assign step       = accept && !plen_zero;

  assign fill1 = fill_q + CNT_W'(1);
  assign full  = (fill1 == plen);

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      len_mask[i] = (CNT_W'(i) < plen);
    end
  end
  assign match_all = full && (&(cell_match | ~len_mask));

  assign win_ctrl.en    = step;
  assign win_ctrl.shift = full && !match_all && !in_req_i.in_last;

  for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_win
    logic [7:0] nb_ins;
    if (g == WIN_DEPTH - 1) begin : g_tail
      assign nb_ins = 8'h00;
    end else begin : g_mid
      assign nb_ins = win_ins[g+1];
    end
    sfr_win_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (win_ctrl),
      .sel_i   (fill_q == CNT_W'(g)),
      .char_i  (in_req_i.in_char),
      .nb_ins_i(nb_ins),
      .pat_i   (pat_bytes_q[8*g +: 8]),
      .ins_o   (win_ins[g]),
      .match_o (cell_match[g])
    );
  end

  // Build the burst for this request.
  always_comb begin
    for (int i = 0; i < OUT_DEPTH; i++) begin
      if (plen_zero) begin
        burst[i] = (i == 0) ? in_req_i.in_char : 8'h00;
      end else if (match_all) begin
        burst[i] = rep_bytes_q[8*i +: 8];
      end else if (i < WIN_DEPTH) begin
        burst[i] = win_ins[i];
      end else begin
        burst[i] = 8'h00;
      end
    end
    if (plen_zero) begin
      burst_cnt = CNT_W'(1);
    end else if (match_all) begin
      burst_cnt = rlen;
    end else if (in_req_i.in_last) begin
      burst_cnt = fill1;
    end else if (full) begin
      burst_cnt = CNT_W'(1);
    end else begin
      burst_cnt = '0;
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cfg_we_i && (cfg_idx_i == CFG_PAT_LEN)) begin
      fill_d = '0;
    end else if (step) begin
      if (match_all || in_req_i.in_last) begin
        fill_d = '0;
      end else if (!full) begin
        fill_d = fill1;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    doc_d = doc_q;
    if (accept) begin
      cnt_d = burst_cnt;
      doc_d = in_req_i.in_last;
    end else if (pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  assign out_ctrl.load = accept;
  assign out_ctrl.pop  = pop;

  for (genvar g = 0; g < OUT_DEPTH; g++) begin : g_out
    logic [7:0] nb;
    if (g == OUT_DEPTH - 1) begin : g_tail
      assign nb = 8'h00;
    end else begin : g_mid
      assign nb = out_byte[g+1];
    end
    sfr_out_cell u_cell (
      .clk_i (clk_i),
      .ctrl_i(out_ctrl),
      .load_i(burst[g]),
      .nb_i  (nb),
      .byte_o(out_byte[g])
    );
  end

  assign out_valid_o        = (cnt_q != '0);
  assign out_req_o.out_char = out_byte[0];
  assign out_req_o.run_end  = (cnt_q == CNT_W'(1));
  assign out_req_o.doc_end  = (cnt_q == CNT_W'(1)) && doc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q   <= '0;
      rep_len_q   <= '0;
      pat_bytes_q <= '0;
      rep_bytes_q <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      doc_q       <= 1'b0;
    end else begin
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
      doc_q  <= doc_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PAT_LEN:   pat_len_q   <= cfg_data_i[LEN_W-1:0];
          CFG_PAT_BYTES: pat_bytes_q <= cfg_data_i;
          CFG_REP_LEN:   rep_len_q   <= cfg_data_i[LEN_W-1:0];
          CFG_REP_BYTES: rep_bytes_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(OUT_DEPTH))
    else $error("output chain count out of range");

  a_fill_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) || (fill_q < plen))
    else $error("window fill reached pattern length");

  a_pass_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && plen_zero) |=> (cnt_q == CNT_W'(1)))
    else $error("pass-through request did not yield one result");

  a_burst_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (cnt_q > CNT_W'(1))) |=> out_valid_o)
    else $error("burst lost bytes while draining");
`endif

endmodule

/* test/find_replace_tb_pkg.sv */
// Scoreboard class that predicts and checks the edited byte stream.
`timescale 1ns / 1ps
package find_replace_tb_pkg;
  import sfr_pkg::*;

  class find_replace_scoreboard;
    logic [3:0]  pat_len_q;
    logic [63:0] pat_bytes_q;
    logic [3:0]  rep_len_q;
    logic [63:0] rep_bytes_q;
    logic [7:0]  window_q [WIN_DEPTH];
    int unsigned fill_q;
    out_req_t    edited_q [$];
    int unsigned errors;

    function new();
      pat_len_q   = '0;
      pat_bytes_q = '0;
      rep_len_q   = '0;
      rep_bytes_q = '0;
      foreach (window_q[i]) window_q[i] = '0;
      fill_q      = 0;
      errors      = 0;
    endfunction

    function int unsigned pattern_size();
      return (pat_len_q > WIN_DEPTH) ? WIN_DEPTH : int'(pat_len_q);
    endfunction

    function int unsigned pending();
      return edited_q.size();
    endfunction

    function void apply_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_PAT_LEN: begin
          // a new length drops whatever the window held
          pat_len_q = data[LEN_W-1:0];
          fill_q    = 0;
        end
        CFG_PAT_BYTES: pat_bytes_q = data;
        CFG_REP_LEN:   rep_len_q   = data[LEN_W-1:0];
        CFG_REP_BYTES: rep_bytes_q = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] pop_oldest();
      logic [7:0] c;
      c = window_q[0];
      for (int i = 1; i < WIN_DEPTH; i++) window_q[i-1] = window_q[i];
      fill_q--;
      return c;
    endfunction

    function void note_request(in_req_t req);
      int unsigned plen;
      int unsigned rlen;
      logic        hit;
      logic [7:0]  bytes_q [$];
      out_req_t    res;
      plen = pattern_size();
      rlen = (rep_len_q > LEN_CAP) ? LEN_CAP : int'(rep_len_q);
      if (plen == 0) begin
        bytes_q = {bytes_q, req.in_char};
      end else begin
        if (fill_q >= plen) fill_q = 0;
        window_q[fill_q] = req.in_char;
        fill_q++;
        if (fill_q == plen) begin
          hit = 1'b1;
          for (int i = 0; i < plen; i++)
            if (window_q[i] != pat_bytes_q[8*i +: 8]) hit = 1'b0;
          if (hit) begin
            for (int i = 0; i < rlen; i++) bytes_q = {bytes_q, rep_bytes_q[8*i +: 8]};
            fill_q = 0;
          end else begin
            bytes_q = {bytes_q, pop_oldest()};
          end
        end
        // end of document: flush the window as is
        if (req.in_last) begin
          while (fill_q > 0) bytes_q = {bytes_q, pop_oldest()};
        end
      end
      foreach (bytes_q[i]) begin
        res.out_char = bytes_q[i];
        res.run_end  = (i == bytes_q.size() - 1);
        res.doc_end  = (i == bytes_q.size() - 1) && req.in_last;
        edited_q = {edited_q, res};
      end
    endfunction

    function void check_result(out_req_t got);
      out_req_t want;
      if (edited_q.size() == 0) begin
        $display("%0t: unexpected byte: actual char %h run_end %b doc_end %b",
                 $time, got.out_char, got.run_end, got.doc_end);
        errors++;
        return;
      end
      want = edited_q.pop_front();
      if (got.out_char !== want.out_char || got.run_end !== want.run_end ||
          got.doc_end !== want.doc_end) begin
        $display("%0t: mismatch: expected char %h run_end %b doc_end %b, actual %h %b %b",
                 $time, want.out_char, want.run_end, want.doc_end,
                 got.out_char, got.run_end, got.doc_end);
        errors++;
      end
    endfunction
  endclass

endpackage

/* test/testbench.sv */
// Top-level testbench for the stream find-and-replace block.
`timescale 1ns / 1ps
module testbench;
  import sfr_pkg::*;
  import find_replace_tb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS   = 370;
  localparam int unsigned PHASE_ITEMS    = 46;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  in_req_t          in_req;
  logic             out_valid;
  logic             out_stall;
  out_req_t         out_req;

  logic        gaps_on;
  logic        stalls_on;
  int unsigned sent;

  find_replace_scoreboard sb;

  stream_find_replace u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (in_valid && !in_stall) sb.note_request(in_req);
    if (out_valid && !out_stall) sb.check_result(out_req);
  end

  // Output side: random stall bursts.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send(logic [7:0] c, logic last);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_req.in_char = c;
    in_req.in_last = last;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Hold the input until every expected byte has come out.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(posedge clk);
    sb.apply_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_phase(logic final_phase);
    logic [7:0]  sym [3];
    logic [63:0] pat;
    logic [63:0] rep;
    logic [3:0]  rlen;
    logic        open_end;
    logic [7:0]  c;
    int unsigned plen;
    int unsigned n;
    int unsigned doc_len;
    int unsigned plant;
    settle();
    gaps_on   = !final_phase && ($urandom_range(0, 3) != 0);
    stalls_on = !final_phase && ($urandom_range(0, 3) != 0);
    sym[0] = 8'($urandom_range(0, 255));
    sym[1] = 8'($urandom_range(0, 255));
    sym[2] = 8'h0A;
    // keep the old length (and window) now and then
    if (final_phase || $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 7))
        0:       write_reg(CFG_PAT_LEN, 64'd0);
        1:       write_reg(CFG_PAT_LEN, 64'd1);
        2:       write_reg(CFG_PAT_LEN, 64'd8);
        3:       write_reg(CFG_PAT_LEN, 64'($urandom_range(9, 15)));
        default: write_reg(CFG_PAT_LEN, 64'($urandom_range(2, 7)));
      endcase
    end
    plen = sb.pattern_size();
    for (int j = 0; j < 8; j++)
      pat[8*j +: 8] = (j < plen) ? sym[$urandom_range(0, 2)] : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0:       rlen = 4'd0;
      1:       rlen = 4'd8;
      2:       rlen = 4'($urandom_range(9, 15));
      default: rlen = 4'($urandom_range(0, 8));
    endcase
    rep = {$urandom, $urandom};
    write_reg(CFG_PAT_BYTES, pat);
    write_reg(CFG_REP_LEN, 64'(rlen));
    write_reg(CFG_REP_BYTES, rep);

    n     = 0;
    plant = 8;
    while (n < PHASE_ITEMS) begin
      doc_len  = $urandom_range(1, 24);
      open_end = !final_phase && (n + doc_len >= PHASE_ITEMS) && ($urandom_range(0, 3) == 0);
      for (int k = 0; k < doc_len; k++) begin
        // mostly planted copies of the pattern and its symbols, some noise
        if (plant >= plen && plen > 0 && $urandom_range(0, 3) == 0) plant = 0;
        if (plant < plen) begin
          c = pat[8*plant +: 8];
          plant++;
        end else if ($urandom_range(0, 2) == 0) begin
          c = 8'($urandom_range(0, 255));
        end else begin
          c = sym[$urandom_range(0, 2)];
        end
        send(c, (k == doc_len - 1) && !open_end);
      end
      n += doc_len;
      if ($urandom_range(0, 5) == 0) settle();
    end
  endtask

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_PAT_LEN;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_req    = '0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    sent      = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Pass-through with the reset configuration.
    send(8'h00, 1'b0);
    send(8'hFF, 1'b1);

    // "ab" -> "XYZ": two matches, then a partial match cut off by the end.
    settle();
    write_reg(CFG_PAT_LEN, 64'd2);
    write_reg(CFG_PAT_BYTES, 64'h6261);
    write_reg(CFG_REP_LEN, 64'd3);
    write_reg(CFG_REP_BYTES, 64'h5A5958);
    send(8'h78, 1'b0);
    send(8'h61, 1'b0);
    send(8'h62, 1'b0);
    send(8'h61, 1'b0);
    send(8'h62, 1'b0);
    send(8'h61, 1'b1);

    // Match across a newline, empty replacement on the final byte.
    settle();
    write_reg(CFG_PAT_LEN, 64'd3);
    write_reg(CFG_PAT_BYTES, 64'h620A61);
    write_reg(CFG_REP_LEN, 64'd0);
    send(8'h61, 1'b0);
    send(8'h0A, 1'b0);
    send(8'h62, 1'b1);

    // Oversized lengths saturate: eight-byte pattern, eight-byte replacement.
    settle();
    write_reg(CFG_PAT_LEN, 64'd15);
    write_reg(CFG_PAT_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_REP_LEN, 64'd15);
    write_reg(CFG_REP_BYTES, 64'h0123_4567_89AB_CDEF);
    repeat (8) send(8'hFF, 1'b0);
    send(8'h00, 1'b1);

    // Length rewritten with bytes in the window: they are dropped.
    repeat (3) send(8'hFF, 1'b0);
    settle();
    write_reg(CFG_PAT_LEN, 64'd1);
    send(8'h41, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) run_phase(sent + PHASE_ITEMS >= RANDOM_ITEMS);

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
